// ===== hw/rtl/rgbrle_pkg.sv =====
// Shared types and constants for the RGB565 run-length encoder.
// No dependencies.
package rgbrle_pkg;

    localparam int PIXEL_W        = 16;
    localparam int TAG_W          = 8;
    localparam int BUDGET_W       = 24;
    localparam int RLE_COUNT_BITS = 24;

    localparam logic [PIXEL_W-1:0]  BLACK_PIXEL  = 16'h0000;
    localparam logic [PIXEL_W-1:0]  SKIP_MAX     = 16'd65535;
    localparam logic [PIXEL_W-1:0]  COLOR_MAX    = 16'd255;
    localparam logic [TAG_W-1:0]    SKIP_TAG     = 8'h00;
    localparam int                  TOKEN_BYTES  = 3;
    localparam logic [BUDGET_W-1:0] BUDGET_MARGIN = 24'd5;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET  = 24'd24576;
    localparam logic [BUDGET_W-1:0] LIMIT_RESET   = BUDGET_RESET - BUDGET_MARGIN;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [TAG_W-1:0]   run_tag;
        logic [PIXEL_W-1:0] run_value;
        logic               dropped;
        logic               last;
    } token_t;

    typedef struct packed {
        logic   v0;
        token_t t0;
        logic   v1;
        token_t t1;
    } tok_pair_t;

endpackage

// ===== hw/rtl/rgbrle_encoder.sv =====
// Run state and token generation: one pixel per advance, up to two tokens out.
// Depends on rgbrle_pkg.
module rgbrle_encoder
    import rgbrle_pkg::*;
#(
    parameter int COUNT_BITS = RLE_COUNT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [PIXEL_W-1:0]  pixel,
    input  logic                frame_end,
    input  logic [BUDGET_W-1:0] limit,
    output tok_pair_t           toks
);

    localparam int CMP_W = (COUNT_BITS > BUDGET_W) ? COUNT_BITS : BUDGET_W;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS+1)'(TOKEN_BYTES);
        sat_add = s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    logic                  open_reg,  open_next;
    logic                  skip_reg,  skip_next;
    logic [PIXEL_W-1:0]    color_reg, color_next;
    logic [PIXEL_W-1:0]    len_reg,   len_next;
    logic [COUNT_BITS-1:0] bw_reg,    bw_next;
    logic                  exh_reg,   exh_next;

    logic                  black, ext, close_prev, close_cur;
    logic                  cur_skip;
    logic [PIXEL_W-1:0]    cur_color, cur_len;
    logic                  drop_x, drop_y;
    logic [COUNT_BITS-1:0] bw_x, bw_y;
    token_t                prev_tok, cur_tok;

    always_comb
    begin
        black = (pixel == BLACK_PIXEL);
        ext   = open_reg & (skip_reg ? (black & (len_reg != SKIP_MAX))
                                     : (!black & (pixel == color_reg) & (len_reg < COLOR_MAX)));

        cur_skip  = ext ? skip_reg  : black;
        cur_color = ext ? color_reg : (black ? BLACK_PIXEL : pixel);
        cur_len   = ext ? (len_reg + PIXEL_W'(1)) : PIXEL_W'(1);

        close_prev = open_reg & !ext;
        close_cur  = (cur_skip ? (cur_len == SKIP_MAX) : (cur_len >= COLOR_MAX)) | frame_end;

        // budget check for first and second emitted token
        drop_x = exh_reg | (CMP_W'(bw_reg) >= CMP_W'(limit));
        bw_x   = drop_x ? bw_reg : sat_add(bw_reg);
        drop_y = drop_x | (CMP_W'(bw_x) >= CMP_W'(limit));
        bw_y   = drop_y ? bw_x : sat_add(bw_x);

        prev_tok.run_tag   = skip_reg ? SKIP_TAG : len_reg[TAG_W-1:0];
        prev_tok.run_value = skip_reg ? len_reg : color_reg;
        prev_tok.dropped   = drop_x;
        prev_tok.last      = 1'b0;

        cur_tok.run_tag   = cur_skip ? SKIP_TAG : cur_len[TAG_W-1:0];
        cur_tok.run_value = cur_skip ? cur_len : cur_color;
        cur_tok.dropped   = close_prev ? drop_y : drop_x;
        cur_tok.last      = frame_end;

        toks.v0 = close_prev | close_cur;
        toks.t0 = close_prev ? prev_tok : cur_tok;
        toks.v1 = close_prev & close_cur;
        toks.t1 = cur_tok;

        open_next  = open_reg;
        skip_next  = skip_reg;
        color_next = color_reg;
        len_next   = len_reg;
        bw_next    = bw_reg;
        exh_next   = exh_reg;
        if (advance)
        begin
            if (frame_end)
            begin
                open_next  = 1'b0;
                skip_next  = 1'b0;
                color_next = BLACK_PIXEL;
                len_next   = '0;
                bw_next    = '0;
                exh_next   = 1'b0;
            end
            else
            begin
                open_next  = !close_cur;
                skip_next  = cur_skip;
                color_next = cur_color;
                len_next   = cur_len;
                if (toks.v1)
                begin
                    bw_next  = bw_y;
                    exh_next = drop_y;
                end
                else if (toks.v0)
                begin
                    bw_next  = bw_x;
                    exh_next = drop_x;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            color_reg <= BLACK_PIXEL;
            len_reg   <= '0;
            bw_reg    <= '0;
            exh_reg   <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            skip_reg  <= skip_next;
            color_reg <= color_next;
            len_reg   <= len_next;
            bw_reg    <= bw_next;
            exh_reg   <= exh_next;
        end
    end

endmodule

// ===== hw/rtl/rgbrle_token_fifo.sv =====
// Small token queue: takes up to two tokens a cycle, gives one.
// Depends on rgbrle_pkg.
module rgbrle_token_fifo
    import rgbrle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tok_pair_t             toks,
    input  logic                  pop,
    output token_t                head,
    output logic [FIFO_CNT_W-1:0] count
);

    token_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   wr0, wr1;
    logic [FIFO_PTR_W-1:0]  wr_ptr_p1;

    always_comb
    begin
        wr0       = push & toks.v0;
        wr1       = push & toks.v1;
        wr_ptr_p1 = wr_ptr_reg + FIFO_PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(wr0) + FIFO_PTR_W'(wr1);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(wr0) + FIFO_CNT_W'(wr1) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            mem_reg[wr_ptr_reg] <= toks.t0;
        end
        if (wr1)
        begin
            mem_reg[wr_ptr_p1] <= toks.t1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== hw/rtl/rgb565_run_length_encoder_core.sv =====
// Top level of the RGB565 run-length encoder with black-pixel skipping.
// Depends on rgbrle_pkg, rgbrle_encoder, rgbrle_token_fifo.
//
//  channel | handshake            | beat
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_stall  | pixel, frame_end
//  out     | out_valid / out_stall| run_tag, run_value, dropped, last
//  cfg     | cfg_valid / cfg_ready| cfg_data (output budget in bytes)
//
// One pixel a cycle unless in_stall is high: input register, run logic, four-entry token queue.
// A token reaches out only after its pixel has passed the input register and been written into the queue.
// A pixel producing two tokens takes two queue slots; input stalls when
// fewer than two are free, so sustained rate holds while tokens average one a pixel.
// Reset clears run state, byte count and queue; the budget returns to 24576.
// cfg_ready is always high; the budget is registered whenever cfg_valid is high.
module rgb565_run_length_encoder_core
    import rgbrle_pkg::*;
#(
    parameter int COUNT_BITS = RLE_COUNT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [PIXEL_W-1:0]  pixel,
    input  logic                frame_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TAG_W-1:0]    run_tag,
    output logic [PIXEL_W-1:0]  run_value,
    output logic                dropped,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BUDGET_W-1:0] cfg_data
);

    logic                  item_valid_reg, item_valid_next;
    logic [PIXEL_W-1:0]    pixel_reg;
    logic                  fend_reg;
    logic [BUDGET_W-1:0]   limit_reg, limit_next;
    logic                  load, advance, pop;
    logic [FIFO_CNT_W-1:0] count;
    tok_pair_t             toks;
    token_t                head;

    assign cfg_ready = 1'b1;
    assign out_valid = (count != '0);
    assign pop       = out_valid & !out_stall;
    assign advance   = item_valid_reg &
                       ((count - FIFO_CNT_W'(pop)) <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign in_stall  = item_valid_reg & !advance;
    assign load      = in_valid & !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (load)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        limit_next = limit_reg;
        if (cfg_valid & cfg_ready)
        begin
            limit_next = (cfg_data >= BUDGET_MARGIN) ? (cfg_data - BUDGET_MARGIN) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            limit_reg      <= LIMIT_RESET;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            limit_reg      <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= pixel;
            fend_reg  <= frame_end;
        end
    end

    rgbrle_encoder #(
        .COUNT_BITS (COUNT_BITS)
    ) u_encoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .pixel     (pixel_reg),
        .frame_end (fend_reg),
        .limit     (limit_reg),
        .toks      (toks)
    );

    rgbrle_token_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (advance),
        .toks  (toks),
        .pop   (pop),
        .head  (head),
        .count (count)
    );

    assign run_tag   = head.run_tag;
    assign run_value = head.run_value;
    assign dropped   = head.dropped;
    assign last      = head.last;

`ifndef SYNTH
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("token queue over capacity");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fend_reg) |-> (toks.v0 && (toks.v1 ? toks.t1.last : toks.t0.last)))
        else $error("frame end without final token");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        toks.v1 |-> toks.v0)
        else $error("second token without first");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (count <= FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("push overran queue");
`endif

endmodule
